>>> design/slcdf_pkg.sv
// shared types, constants and record codes for the serial lcd window framer
package slcdf_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned RECORD_W = 28;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STEP_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WINDOW = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ORIENT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT  = 2'd3;

    // register reset values
    localparam logic [COORD_W-1:0] RST_COLUMN_OFFSET = 16'd40;
    localparam logic [COORD_W-1:0] RST_ROW_OFFSET    = 16'd53;
    localparam logic [COORD_W-1:0] RST_WIDTH_LIMIT   = 16'd240;
    localparam logic [COORD_W-1:0] RST_HEIGHT_LIMIT  = 16'd135;

    // record masks and command bytes
    localparam logic [RECORD_W-1:0] SEL_HIGH_MASK = 28'h0ff00000;
    localparam logic [RECORD_W-1:0] CMD_MASK      = 28'h0003fc00;
    localparam logic [RECORD_W-1:0] IDLE_RECORD   = SEL_HIGH_MASK | CMD_MASK;
    localparam logic [BYTE_W-1:0]   CMD_COLUMN    = 8'h2A;
    localparam logic [BYTE_W-1:0]   CMD_ROW       = 8'h2B;
    localparam logic [BYTE_W-1:0]   CMD_MEMWRITE  = 8'h2C;
    localparam logic [BYTE_W-1:0]   CMD_ORIENT    = 8'h36;

    // final step of each kind's record sequence
    localparam logic [STEP_W-1:0] LAST_STEP_WINDOW = 4'd13;
    localparam logic [STEP_W-1:0] LAST_STEP_PIXEL  = 4'd1;
    localparam logic [STEP_W-1:0] LAST_STEP_ORIENT = 4'd2;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // one classified item between front and back
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] w0;   // column start, pixel or orientation
        logic [COORD_W-1:0] w1;   // column end
        logic [COORD_W-1:0] w2;   // row start
        logic [COORD_W-1:0] w3;   // row end
    } job_t;

endpackage

>>> design/slcdf_front.sv
// front part: accepts items, clamps and offsets window bounds, pushes jobs
module slcdf_front (
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [slcdf_pkg::KIND_W-1:0]  s_kind,
    input  logic signed [15:0]            s_x_start,
    input  logic signed [15:0]            s_x_end,
    input  logic signed [15:0]            s_y_start,
    input  logic signed [15:0]            s_y_end,
    input  logic [15:0]                   s_pixel,
    input  logic [7:0]                    s_orientation,
    input  logic [slcdf_pkg::COORD_W-1:0] column_offset,
    input  logic [slcdf_pkg::COORD_W-1:0] row_offset,
    input  logic [slcdf_pkg::COORD_W-1:0] width_limit,
    input  logic [slcdf_pkg::COORD_W-1:0] height_limit,
    input  logic                          queue_full,
    output logic                          push,
    output slcdf_pkg::job_t               push_job
);

    function automatic logic [slcdf_pkg::COORD_W-1:0] clamp_start(
        input logic [slcdf_pkg::COORD_W-1:0] v
    );
        clamp_start = v[slcdf_pkg::COORD_W-1] ? '0 : v;
    endfunction

    // negative ends pass through as their bit pattern
    function automatic logic [slcdf_pkg::COORD_W-1:0] clamp_end(
        input logic [slcdf_pkg::COORD_W-1:0] v,
        input logic [slcdf_pkg::COORD_W-1:0] lim
    );
        clamp_end = (!v[slcdf_pkg::COORD_W-1] && (v > lim)) ? lim : v;
    endfunction

    logic [slcdf_pkg::COORD_W-1:0] xs, xe, ys, ye;

    assign xs = clamp_start(s_x_start) + column_offset;
    assign xe = clamp_end(s_x_end, width_limit) + column_offset;
    assign ys = clamp_start(s_y_start) + row_offset;
    assign ye = clamp_end(s_y_end, height_limit) + row_offset;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full && (s_kind != slcdf_pkg::KIND_NONE);

    always_comb begin
        push_job.kind = s_kind;
        push_job.w1   = xe;
        push_job.w2   = ys;
        push_job.w3   = ye;
        case (s_kind)
            slcdf_pkg::KIND_WINDOW: push_job.w0 = xs;
            slcdf_pkg::KIND_PIXEL:  push_job.w0 = s_pixel;
            slcdf_pkg::KIND_ORIENT: push_job.w0 = {8'h00, s_orientation};
            default:                push_job.w0 = xs;
        endcase
    end

endmodule

>>> design/slcdf_queue.sv
// short job queue between front and back
module slcdf_queue #(
    parameter int unsigned DEPTH = slcdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  slcdf_pkg::job_t push_job,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output slcdf_pkg::job_t head_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    slcdf_pkg::job_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> design/slcdf_back.sv
// back part: steps through a job's record sequence into the output register
module slcdf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            queue_empty,
    input  slcdf_pkg::job_t                 head_job,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [slcdf_pkg::RECORD_W-1:0]  m_record,
    output logic                            m_last
);

    logic [slcdf_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                           m_valid_reg, m_valid_next;
    logic [slcdf_pkg::RECORD_W-1:0] m_record_reg, m_record_next;
    logic                           m_last_reg, m_last_next;
    logic                           advance;
    logic [slcdf_pkg::RECORD_W-1:0] rec;
    logic                           rec_last;

    function automatic logic [slcdf_pkg::RECORD_W-1:0] data_rec(
        input logic [slcdf_pkg::BYTE_W-1:0] b
    );
        data_rec = {{(slcdf_pkg::RECORD_W - slcdf_pkg::BYTE_W){1'b0}}, b};
    endfunction

    function automatic logic [slcdf_pkg::RECORD_W-1:0] cmd_rec(
        input logic [slcdf_pkg::BYTE_W-1:0] b
    );
        cmd_rec = slcdf_pkg::CMD_MASK | data_rec(b);
    endfunction

    // record for the current step of the head job
    always_comb begin
        rec      = slcdf_pkg::IDLE_RECORD;
        rec_last = 1'b0;
        case (head_job.kind)
            slcdf_pkg::KIND_WINDOW: begin
                rec_last = (step_reg == slcdf_pkg::LAST_STEP_WINDOW);
                case (step_reg)
                    4'd0:    rec = slcdf_pkg::IDLE_RECORD;
                    4'd1:    rec = cmd_rec(slcdf_pkg::CMD_COLUMN);
                    4'd2:    rec = data_rec(head_job.w0[15:8]);
                    4'd3:    rec = data_rec(head_job.w0[7:0]);
                    4'd4:    rec = data_rec(head_job.w1[15:8]);
                    4'd5:    rec = data_rec(head_job.w1[7:0]);
                    4'd6:    rec = slcdf_pkg::IDLE_RECORD;
                    4'd7:    rec = cmd_rec(slcdf_pkg::CMD_ROW);
                    4'd8:    rec = data_rec(head_job.w2[15:8]);
                    4'd9:    rec = data_rec(head_job.w2[7:0]);
                    4'd10:   rec = data_rec(head_job.w3[15:8]);
                    4'd11:   rec = data_rec(head_job.w3[7:0]);
                    4'd12:   rec = slcdf_pkg::IDLE_RECORD;
                    default: rec = cmd_rec(slcdf_pkg::CMD_MEMWRITE);
                endcase
            end
            slcdf_pkg::KIND_PIXEL: begin
                rec_last = (step_reg == slcdf_pkg::LAST_STEP_PIXEL);
                rec = rec_last ? data_rec(head_job.w0[7:0]) : data_rec(head_job.w0[15:8]);
            end
            slcdf_pkg::KIND_ORIENT: begin
                rec_last = (step_reg == slcdf_pkg::LAST_STEP_ORIENT);
                case (step_reg)
                    4'd0:    rec = slcdf_pkg::IDLE_RECORD;
                    4'd1:    rec = cmd_rec(slcdf_pkg::CMD_ORIENT);
                    default: rec = data_rec(head_job.w0[7:0]);
                endcase
            end
            default: begin
                rec      = slcdf_pkg::IDLE_RECORD;
                rec_last = 1'b1;
            end
        endcase
    end

    assign advance = !queue_empty && (!m_valid_reg || m_ready);
    assign pop     = advance && rec_last;

    always_comb begin
        step_next     = step_reg;
        m_valid_next  = m_valid_reg;
        m_record_next = m_record_reg;
        m_last_next   = m_last_reg;
        if (advance) begin
            m_valid_next  = 1'b1;
            m_record_next = rec;
            m_last_next   = rec_last;
            step_next     = rec_last ? '0 : step_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_record_reg <= m_record_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_record = m_record_reg;
    assign m_last   = m_last_reg;

endmodule

>>> design/spi_lcd_command_window_framer_core.sv
// top level of the serial lcd window framer: config registers, front, queue, back
// an item's first record is registered in the queue, then in the back part's output register
// one record per cycle from the back part's output register while the receiver takes
//   them; a pixel item gives 2 records, an orientation item 3 and a window item 14
// kind 3 items are accepted and dropped without any record
// reset: queue and output register empty, offsets 40/53, limits 240/135
module spi_lcd_command_window_framer_core #(
    parameter int unsigned QUEUE_DEPTH = slcdf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [slcdf_pkg::KIND_W-1:0]     s_kind,
    input  logic signed [15:0]               s_x_start,
    input  logic signed [15:0]               s_x_end,
    input  logic signed [15:0]               s_y_start,
    input  logic signed [15:0]               s_y_end,
    input  logic [15:0]                      s_pixel,
    input  logic [7:0]                       s_orientation,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [slcdf_pkg::RECORD_W-1:0]   m_record,
    output logic                             m_last,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [slcdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [slcdf_pkg::COORD_W-1:0]    cfg_data
);

    // configuration registers
    logic [slcdf_pkg::COORD_W-1:0] column_offset_reg;
    logic [slcdf_pkg::COORD_W-1:0] row_offset_reg;
    logic [slcdf_pkg::COORD_W-1:0] width_limit_reg;
    logic [slcdf_pkg::COORD_W-1:0] height_limit_reg;

    // front to queue
    logic            push;
    slcdf_pkg::job_t push_job;
    logic            queue_full;

    // queue to back
    logic            pop;
    logic            queue_empty;
    slcdf_pkg::job_t head_job;

    // plain register writes; the user must write only while the block is idle, the block itself does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_offset_reg <= slcdf_pkg::RST_COLUMN_OFFSET;
            row_offset_reg    <= slcdf_pkg::RST_ROW_OFFSET;
            width_limit_reg   <= slcdf_pkg::RST_WIDTH_LIMIT;
            height_limit_reg  <= slcdf_pkg::RST_HEIGHT_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                slcdf_pkg::CFG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                slcdf_pkg::CFG_ROW_OFFSET:    row_offset_reg    <= cfg_data;
                slcdf_pkg::CFG_WIDTH_LIMIT:   width_limit_reg   <= cfg_data;
                slcdf_pkg::CFG_HEIGHT_LIMIT:  height_limit_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: classify the beat, clamp and offset the window bounds
    slcdf_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_x_start     (s_x_start),
        .s_x_end       (s_x_end),
        .s_y_start     (s_y_start),
        .s_y_end       (s_y_end),
        .s_pixel       (s_pixel),
        .s_orientation (s_orientation),
        .column_offset (column_offset_reg),
        .row_offset    (row_offset_reg),
        .width_limit   (width_limit_reg),
        .height_limit  (height_limit_reg),
        .queue_full    (queue_full),
        .push          (push),
        .push_job      (push_job)
    );

    // short queue decouples input stalls from output stalls
    slcdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head_job (head_job)
    );

    // back: one record per cycle while the receiver takes them, pops the job on its final record
    slcdf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (queue_empty),
        .head_job    (head_job),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_record    (m_record),
        .m_last      (m_last)
    );

endmodule

>>> sim/tb.sv
// self-checking testbench for the serial lcd window framer: random and directed requests
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles allowed after the last record before the block counts as idle
    localparam int unsigned SETTLE_CYCLES = 8;
    // length of the long receiver hold-off that backs the block up
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 95;

    // one request as offered on the input channel
    typedef struct packed {
        logic [slcdf_pkg::KIND_W-1:0] kind;
        logic signed [15:0]           x_start;
        logic signed [15:0]           x_end;
        logic signed [15:0]           y_start;
        logic signed [15:0]           y_end;
        logic [15:0]                  pixel;
        logic [7:0]                   orient;
    } lcd_req_t;

    // one serial record as it should leave the block
    typedef struct packed {
        logic [slcdf_pkg::RECORD_W-1:0] rec;
        logic                           last;
    } lcd_rec_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                            s_valid       = 1'b0;
    logic                            s_ready;
    logic [slcdf_pkg::KIND_W-1:0]    s_kind        = slcdf_pkg::KIND_NONE;
    logic signed [15:0]              s_x_start     = '0;
    logic signed [15:0]              s_x_end       = '0;
    logic signed [15:0]              s_y_start     = '0;
    logic signed [15:0]              s_y_end       = '0;
    logic [15:0]                     s_pixel       = '0;
    logic [7:0]                      s_orientation = '0;

    logic                            m_valid;
    logic                            m_ready       = 1'b0;
    logic [slcdf_pkg::RECORD_W-1:0]  m_record;
    logic                            m_last;

    logic                            cfg_wr_en     = 1'b0;
    logic [slcdf_pkg::CFG_IDX_W-1:0] cfg_index     = slcdf_pkg::CFG_COLUMN_OFFSET;
    logic [slcdf_pkg::COORD_W-1:0]   cfg_data      = '0;

    // requests waiting to be offered, records owed by the block
    lcd_req_t req_queue[$];
    lcd_rec_t owed_records[$];
    lcd_req_t offered_req;

    // our own copy of the register file
    logic [slcdf_pkg::COORD_W-1:0] cfg_col_offset = slcdf_pkg::RST_COLUMN_OFFSET;
    logic [slcdf_pkg::COORD_W-1:0] cfg_row_offset = slcdf_pkg::RST_ROW_OFFSET;
    logic [slcdf_pkg::COORD_W-1:0] cfg_width_lim  = slcdf_pkg::RST_WIDTH_LIMIT;
    logic [slcdf_pkg::COORD_W-1:0] cfg_height_lim = slcdf_pkg::RST_HEIGHT_LIMIT;

    // idling knobs, percent of cycles
    int unsigned sender_idle_pct = 0;
    int unsigned stall_pct       = 0;

    // long hold-off: the stimulus flips hold_req, the receiver counts it out
    logic        hold_req  = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    int unsigned fail_count = 0;

    spi_lcd_command_window_framer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_x_start     (s_x_start),
        .s_x_end       (s_x_end),
        .s_y_start     (s_y_start),
        .s_y_end       (s_y_end),
        .s_pixel       (s_pixel),
        .s_orientation (s_orientation),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_record      (m_record),
        .m_last        (m_last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // record predictor
    // ------------------------------------------------------------------

    function automatic void owe_record(logic [slcdf_pkg::RECORD_W-1:0] rec);
        lcd_rec_t e;
        e.rec  = rec;
        e.last = 1'b0;
        owed_records.push_back(e);
    endfunction

    // every command goes out behind one select-high idle record
    function automatic void owe_command(logic [slcdf_pkg::BYTE_W-1:0] cmd);
        owe_record(slcdf_pkg::IDLE_RECORD);
        owe_record(slcdf_pkg::CMD_MASK | slcdf_pkg::RECORD_W'(cmd));
    endfunction

    // start and end plus offset, wrapped to 16 bits, high byte first
    function automatic void owe_bounds(int lo, int hi, logic [slcdf_pkg::COORD_W-1:0] off);
        logic [15:0] a;
        logic [15:0] b;
        a = 16'(lo + int'(off));
        b = 16'(hi + int'(off));
        owe_record(slcdf_pkg::RECORD_W'(a[15:8]));
        owe_record(slcdf_pkg::RECORD_W'(a[7:0]));
        owe_record(slcdf_pkg::RECORD_W'(b[15:8]));
        owe_record(slcdf_pkg::RECORD_W'(b[7:0]));
    endfunction

    function automatic void frame_request(lcd_req_t r);
        int xs;
        int xe;
        int ys;
        int ye;
        int unsigned owed_before;
        owed_before = owed_records.size();
        case (r.kind)
            slcdf_pkg::KIND_WINDOW: begin
                xs = $signed(r.x_start);
                xe = $signed(r.x_end);
                ys = $signed(r.y_start);
                ye = $signed(r.y_end);
                // starts clamp at zero, ends clamp at the limit only from above
                if (xs < 0) xs = 0;
                if (ys < 0) ys = 0;
                if (xe > int'(cfg_width_lim)) xe = int'(cfg_width_lim);
                if (ye > int'(cfg_height_lim)) ye = int'(cfg_height_lim);
                owe_command(slcdf_pkg::CMD_COLUMN);
                owe_bounds(xs, xe, cfg_col_offset);
                owe_command(slcdf_pkg::CMD_ROW);
                owe_bounds(ys, ye, cfg_row_offset);
                owe_command(slcdf_pkg::CMD_MEMWRITE);
            end
            slcdf_pkg::KIND_PIXEL: begin
                owe_record(slcdf_pkg::RECORD_W'(r.pixel[15:8]));
                owe_record(slcdf_pkg::RECORD_W'(r.pixel[7:0]));
            end
            slcdf_pkg::KIND_ORIENT: begin
                owe_command(slcdf_pkg::CMD_ORIENT);
                owe_record(slcdf_pkg::RECORD_W'(r.orient));
            end
            default: begin
                // unused kind is swallowed without records
            end
        endcase
        if (owed_records.size() > owed_before)
            owed_records[owed_records.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // request builders
    // ------------------------------------------------------------------

    // unused fields get random content so the block must ignore them
    function automatic lcd_req_t noise_req(logic [slcdf_pkg::KIND_W-1:0] kind);
        lcd_req_t r;
        r.kind    = kind;
        r.x_start = 16'($urandom);
        r.x_end   = 16'($urandom);
        r.y_start = 16'($urandom);
        r.y_end   = 16'($urandom);
        r.pixel   = 16'($urandom);
        r.orient  = 8'($urandom);
        return r;
    endfunction

    function automatic lcd_req_t window_req(int xs, int xe, int ys, int ye);
        lcd_req_t r;
        r         = noise_req(slcdf_pkg::KIND_WINDOW);
        r.x_start = 16'(xs);
        r.x_end   = 16'(xe);
        r.y_start = 16'(ys);
        r.y_end   = 16'(ye);
        return r;
    endfunction

    function automatic lcd_req_t pixel_req(logic [15:0] px);
        lcd_req_t r;
        r       = noise_req(slcdf_pkg::KIND_PIXEL);
        r.pixel = px;
        return r;
    endfunction

    function automatic lcd_req_t orient_req(logic [7:0] o);
        lcd_req_t r;
        r        = noise_req(slcdf_pkg::KIND_ORIENT);
        r.orient = o;
        return r;
    endfunction

    // near the limit in two of five draws, so clamping both hits and misses
    function automatic int rand_coord(logic [slcdf_pkg::COORD_W-1:0] lim);
        case ($urandom_range(4))
            0, 1: begin
                return int'($urandom_range(int'(lim) + 8));
            end
            2: begin
                return -int'($urandom_range(1, 300));
            end
            default: begin
                return int'($signed(16'($urandom)));
            end
        endcase
    endfunction

    // pixels dominate as in real use, with windows and orientation mixed in
    function automatic lcd_req_t rand_request();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 15)
            return window_req(rand_coord(cfg_width_lim), rand_coord(cfg_width_lim),
                              rand_coord(cfg_height_lim), rand_coord(cfg_height_lim));
        else if (pick < 75)
            return pixel_req(16'($urandom));
        else if (pick < 90)
            return orient_req(8'($urandom));
        else
            return noise_req(slcdf_pkg::KIND_NONE);
    endfunction

    // ------------------------------------------------------------------
    // input driver: one beat offered at a time from req_queue
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_requests
        lcd_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // beat taken this edge, predict its records now
            if (s_valid)
                frame_request(offered_req);
            if (req_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                nxt           = req_queue.pop_front();
                offered_req   = nxt;
                s_valid       <= 1'b1;
                s_kind        <= nxt.kind;
                s_x_start     <= nxt.x_start;
                s_x_end       <= nxt.x_end;
                s_y_start     <= nxt.y_start;
                s_y_end       <= nxt.y_end;
                s_pixel       <= nxt.pixel;
                s_orientation <= nxt.orient;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_OFF_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: every record beat against the oldest owed record
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_records
        lcd_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_records.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= 10)
                    $display("record beat with nothing owed: record %07h last %0b",
                             m_record, m_last);
            end else begin
                want = owed_records.pop_front();
                if (m_record !== want.rec || m_last !== want.last) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10)
                        $display("record mismatch: expected %07h last %0b, got %07h last %0b",
                                 want.rec, want.last, m_record, m_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic write_reg(logic [slcdf_pkg::CFG_IDX_W-1:0] idx,
                             logic [slcdf_pkg::COORD_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            slcdf_pkg::CFG_COLUMN_OFFSET: cfg_col_offset = val;
            slcdf_pkg::CFG_ROW_OFFSET:    cfg_row_offset = val;
            slcdf_pkg::CFG_WIDTH_LIMIT:   cfg_width_lim  = val;
            default:                      cfg_height_lim = val;
        endcase
    endtask

    // only called while the block is drained
    task automatic set_regs(logic [15:0] col_off, logic [15:0] row_off,
                            logic [15:0] w_lim, logic [15:0] h_lim);
        write_reg(slcdf_pkg::CFG_COLUMN_OFFSET, col_off);
        write_reg(slcdf_pkg::CFG_ROW_OFFSET, row_off);
        write_reg(slcdf_pkg::CFG_WIDTH_LIMIT, w_lim);
        write_reg(slcdf_pkg::CFG_HEIGHT_LIMIT, h_lim);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every request went in and every owed record came out,
    // then let the pipe settle for SETTLE_CYCLES
    task automatic drain();
        while (req_queue.size() != 0 || s_valid || owed_records.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_random(int unsigned idle_pct, int unsigned stall, int unsigned count);
        sender_idle_pct = idle_pct;
        stall_pct       = stall;
        repeat (count) req_queue.push_back(rand_request());
        drain();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed pass at reset values, no idling
        sender_idle_pct = 0;
        stall_pct       = 0;
        req_queue.push_back(window_req(0, 239, 0, 134));
        // negative starts, ends far above the limits
        req_queue.push_back(window_req(-32768, 32767, -1, 32767));
        // negative ends pass through as raw patterns
        req_queue.push_back(window_req(5, -3, 7, -32768));
        // start after end goes out unchecked
        req_queue.push_back(window_req(100, 50, 90, 10));
        // ends right at and one past the limits
        req_queue.push_back(window_req(240, 240, 135, 135));
        req_queue.push_back(window_req(241, 241, 136, 136));
        // large starts are not clamped
        req_queue.push_back(window_req(32767, 0, 32767, 0));
        req_queue.push_back(pixel_req(16'h0000));
        req_queue.push_back(pixel_req(16'hffff));
        req_queue.push_back(pixel_req(16'ha55a));
        req_queue.push_back(pixel_req(16'h5aa5));
        req_queue.push_back(pixel_req(16'h8001));
        req_queue.push_back(orient_req(8'h00));
        req_queue.push_back(orient_req(8'hff));
        req_queue.push_back(orient_req(8'ha5));
        // unused kind between real beats
        req_queue.push_back(noise_req(slcdf_pkg::KIND_NONE));
        req_queue.push_back(pixel_req(16'h1234));
        req_queue.push_back(noise_req(slcdf_pkg::KIND_NONE));
        req_queue.push_back(orient_req(8'h5a));
        drain();

        // all registers at their maximum, offsets wrap; sender mostly idle
        set_regs(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        req_queue.push_back(window_req(1, 2, 32767, -1));
        req_queue.push_back(window_req(-5, 32767, 0, -32768));
        run_random(75, 0, PHASE_ITEMS);

        // all registers zero, every non-negative end clamps to zero; receiver mostly stalled
        set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(0, 75, PHASE_ITEMS);

        // random offsets with small limits; light idling on both sides
        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(400)),
                 16'($urandom_range(400)));
        run_random(7, 7, PHASE_ITEMS);

        // long receiver hold-off while the sender keeps offering beats
        set_regs(slcdf_pkg::RST_COLUMN_OFFSET, slcdf_pkg::RST_ROW_OFFSET,
                 slcdf_pkg::RST_WIDTH_LIMIT, slcdf_pkg::RST_HEIGHT_LIMIT);
        hold_req = ~hold_req;
        run_random(0, 0, PHASE_ITEMS);

        // fully random register values, no idling
        set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_random(0, 0, PHASE_ITEMS);

        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

endmodule
